FILE: rtl/stwg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stwg_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int AMP_W       = 16;
	localparam int OFFSET_W    = 16;
	localparam int STEP_W      = 32;
	localparam int COUNT_W     = 32;
	localparam int MIX_W       = 18;
	localparam int SCALED_W    = 18;
	localparam int SAMPLE_W    = 19;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_WAVE_SELECT  = 3'd0,
		CFG_AMPLITUDE    = 3'd1,
		CFG_PHASE_STEP   = 3'd2,
		CFG_OFFSET       = 3'd3,
		CFG_SAMPLE_COUNT = 3'd4,
		CFG_MIX_ENABLE   = 3'd5
	} cfg_index_t;

	localparam logic [1:0] WAVE_SINE     = 2'd0;
	localparam logic [1:0] WAVE_TRIANGLE = 2'd1;

	// Q30 fixed point constants for building the quarter-wave sine table.
	localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
	localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
	localparam int          SERIES_LEN  = 6;
	localparam logic [7:0]  SERIES_DIV [SERIES_LEN] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};

endpackage

`default_nettype wire

FILE: rtl/sine_triangle_wave_generator.sv
`timescale 1ns / 1ps
`default_nettype none

// A sample passes through the stage one, two and three registers, then the output register.
// Throughput: one request per cycle unless out_ready stalls the pipeline, set by the
// single-pass pipeline of table read, amplitude multiply, rounding and final add.
// Reset clears the configuration registers, the valid flags, the phase and the sample
// counter, and leaves the generator idle until a request with start_req set arrives.
module sine_triangle_wave_generator
	import stwg_pkg::*;
#(
	parameter int PHASE_BITS      = 32,
	parameter int TABLE_ADDR_BITS = 10,
	parameter int SINE_FRAC_BITS  = 15
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,

	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [CFG_DATA_W-1:0]      cfg_data,

	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic                       start_req,
	input  wire logic signed [MIX_W-1:0]    mix_sample,

	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic signed [SAMPLE_W-1:0]      sample,
	output logic [COUNT_W-1:0]              sample_index,
	output logic                            last
);

	localparam int TAB_LEN  = (2 ** TABLE_ADDR_BITS) + 1;
	localparam int UNIT_W   = SINE_FRAC_BITS + 1;
	localparam int PROD_W   = AMP_W + UNIT_W;
	localparam int TRI_W    = SINE_FRAC_BITS + 2;
	localparam int ROUND_SH = 30 - SINE_FRAC_BITS;
	localparam logic [TABLE_ADDR_BITS:0] TAB_FULL = (TABLE_ADDR_BITS + 1)'(2 ** TABLE_ADDR_BITS);
	localparam logic [UNIT_W-1:0] UNIT_ONE = UNIT_W'(2 ** SINE_FRAC_BITS);
	localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << (SINE_FRAC_BITS - 1);

	typedef logic [UNIT_W-1:0] sin_tab_t [TAB_LEN];

	function automatic logic [63:0] sine_q30(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] d;
		x2 = (x * x) >> 30;
		t  = Q30_ONE;
		for (int i = 0; i < SERIES_LEN; i++) begin
			d = ((x2 * t) >> 30) / 64'(SERIES_DIV[i]);
			t = (d > Q30_ONE) ? 64'd0 : Q30_ONE - d;
		end
		return (x * t) >> 30;
	endfunction

	function automatic sin_tab_t build_sin_tab();
		sin_tab_t    tab;
		logic [63:0] x;
		logic [63:0] s;
		logic [63:0] v;
		logic [63:0] cap;
		cap = 64'd1 << SINE_FRAC_BITS;
		for (int k = 0; k < TAB_LEN; k++) begin
			x = (Q30_HALF_PI * 64'(k)) >> TABLE_ADDR_BITS;
			s = sine_q30(x);
			v = (s + (64'd1 << (ROUND_SH - 1))) >> ROUND_SH;
			tab[k] = UNIT_W'((v > cap) ? cap : v);
		end
		return tab;
	endfunction

	localparam sin_tab_t SIN_TAB = build_sin_tab();

	// Configuration registers.
	logic                  wave_sel_q;
	logic [AMP_W-1:0]      amplitude_q;
	logic [STEP_W-1:0]     phase_step_q;
	logic [OFFSET_W-1:0]   offset_q;
	logic [COUNT_W-1:0]    sample_count_q;
	logic                  mix_en_q;

	// Sequence state.
	logic [PHASE_BITS-1:0] phase_q;
	logic [COUNT_W-1:0]    counter_q;
	logic                  finished_q;

	// Stage one: table read and triangle fold.
	logic                  v_s1;
	logic [UNIT_W-1:0]     rom_s1;
	logic [UNIT_W-1:0]     tri_s1;
	logic                  neg_s1;
	logic                  wave_sel_s1;
	logic [AMP_W-1:0]      amp_s1;
	logic [OFFSET_W-1:0]   offset_s1;
	logic                  mix_en_s1;
	logic [MIX_W-1:0]      mix_s1;
	logic [COUNT_W-1:0]    index_s1;
	logic                  last_s1;

	// Stage two: amplitude product.
	logic                  v_s2;
	logic [PROD_W-1:0]     prod_s2;
	logic                  neg_s2;
	logic [OFFSET_W-1:0]   offset_s2;
	logic                  mix_en_s2;
	logic [MIX_W-1:0]      mix_s2;
	logic [COUNT_W-1:0]    index_s2;
	logic                  last_s2;

	// Stage three: rounded, signed sample.
	logic                  v_s3;
	logic [SCALED_W-1:0]   scaled_s3;
	logic [OFFSET_W-1:0]   offset_s3;
	logic                  mix_en_s3;
	logic [MIX_W-1:0]      mix_s3;
	logic [COUNT_W-1:0]    index_s3;
	logic                  last_s3;

	// Output register.
	logic                  out_valid_q;
	logic [SAMPLE_W-1:0]   sample_q;
	logic [COUNT_W-1:0]    index_q;
	logic                  last_q;

	logic                  en1;
	logic                  en2;
	logic                  en3;
	logic                  en_o;
	logic                  accept;

	logic [PHASE_BITS-1:0] phase_use;
	logic [PHASE_BITS-1:0] step_p;
	logic [COUNT_W-1:0]    index_use;
	logic                  finished_use;
	logic                  produce;
	logic                  is_last;
	logic [COUNT_W:0]      index_inc;

	logic [1:0]                   quad;
	logic [TABLE_ADDR_BITS-1:0]   tab_a;
	logic [TABLE_ADDR_BITS:0]     rom_addr;
	logic [PHASE_BITS+TRI_W-1:0]  phase_pad;
	logic [TRI_W-1:0]             tri_p;
	logic [SINE_FRAC_BITS-1:0]    tri_r;
	logic [UNIT_W-1:0]            tri_mag;

	logic [UNIT_W-1:0]            unit_mag;
	logic [PROD_W-1:0]            rnd_sum;
	logic [SCALED_W-1:0]          mag_r;
	logic [SAMPLE_W-1:0]          mix_term;

	// Configuration port.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_sel_q     <= 1'b0;
			amplitude_q    <= '0;
			phase_step_q   <= '0;
			offset_q       <= '0;
			sample_count_q <= '0;
			mix_en_q       <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_WAVE_SELECT:  wave_sel_q     <= cfg_data[0];
				CFG_AMPLITUDE:    amplitude_q    <= cfg_data[AMP_W-1:0];
				CFG_PHASE_STEP:   phase_step_q   <= cfg_data[STEP_W-1:0];
				CFG_OFFSET:       offset_q       <= cfg_data[OFFSET_W-1:0];
				CFG_SAMPLE_COUNT: sample_count_q <= cfg_data[COUNT_W-1:0];
				CFG_MIX_ENABLE:   mix_en_q       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Pipeline flow control.
	assign en_o     = !out_valid_q || out_ready;
	assign en3      = !v_s3 || en_o;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;
	assign accept   = in_valid && in_ready;

	// Sequence control for the request being accepted.
	assign phase_use    = start_req ? '0 : phase_q;
	assign index_use    = start_req ? '0 : counter_q;
	assign finished_use = start_req ? (sample_count_q == '0) : finished_q;
	assign produce      = !finished_use;
	assign index_inc    = {1'b0, index_use} + (COUNT_W + 1)'(1);
	assign is_last      = index_inc >= {1'b0, sample_count_q};
	assign step_p       = PHASE_BITS'({{PHASE_BITS{1'b0}}, phase_step_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= '0;
			counter_q  <= '0;
			finished_q <= 1'b1;
		end else if (accept) begin
			if (produce) begin
				phase_q    <= phase_use + step_p;
				counter_q  <= index_inc[COUNT_W-1:0];
				finished_q <= is_last;
			end else begin
				phase_q    <= phase_use;
				counter_q  <= index_use;
				finished_q <= 1'b1;
			end
		end
	end

	// Phase to table address and triangle value.
	assign quad      = phase_use[PHASE_BITS-1 -: 2];
	assign tab_a     = phase_use[PHASE_BITS-3 -: TABLE_ADDR_BITS];
	assign rom_addr  = quad[0] ? (TAB_FULL - {1'b0, tab_a}) : {1'b0, tab_a};
	assign phase_pad = {phase_use, {TRI_W{1'b0}}};
	assign tri_p     = phase_pad[PHASE_BITS+TRI_W-1 -: TRI_W];
	assign tri_r     = tri_p[SINE_FRAC_BITS-1:0];
	assign tri_mag   = tri_p[SINE_FRAC_BITS] ? (UNIT_ONE - {1'b0, tri_r}) : {1'b0, tri_r};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= accept && produce;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			rom_s1      <= SIN_TAB[rom_addr];
			tri_s1      <= tri_mag;
			neg_s1      <= quad[1];
			wave_sel_s1 <= wave_sel_q;
			amp_s1      <= amplitude_q;
			offset_s1   <= offset_q;
			mix_en_s1   <= mix_en_q;
			mix_s1      <= mix_sample;
			index_s1    <= index_use;
			last_s1     <= is_last;
		end
	end

	// Magnitude times amplitude; the sign travels alongside.
	assign unit_mag = (wave_sel_s1 == WAVE_TRIANGLE[0]) ? tri_s1 : rom_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			prod_s2   <= PROD_W'(amp_s1) * PROD_W'(unit_mag);
			neg_s2    <= neg_s1;
			offset_s2 <= offset_s1;
			mix_en_s2 <= mix_en_s1;
			mix_s2    <= mix_s1;
			index_s2  <= index_s1;
			last_s2   <= last_s1;
		end
	end

	// Rounding half away from zero is done on the magnitude.
	assign rnd_sum = prod_s2 + RND_HALF;
	assign mag_r   = {1'b0, rnd_sum[PROD_W-1:SINE_FRAC_BITS]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			scaled_s3 <= neg_s2 ? (SCALED_W'(0) - mag_r) : mag_r;
			offset_s3 <= offset_s2;
			mix_en_s3 <= mix_en_s2;
			mix_s3    <= mix_s2;
			index_s3  <= index_s2;
			last_s3   <= last_s2;
		end
	end

	assign mix_term = mix_en_s3 ? {mix_s3[MIX_W-1], mix_s3} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_o) begin
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_o) begin
			sample_q <= {scaled_s3[SCALED_W-1], scaled_s3}
				+ {{(SAMPLE_W - OFFSET_W){1'b0}}, offset_s3}
				+ mix_term;
			index_q  <= index_s3;
			last_q   <= last_s3;
		end
	end

	assign out_valid    = out_valid_q;
	assign sample       = $signed(sample_q);
	assign sample_index = index_q;
	assign last         = last_q;

endmodule

`default_nettype wire

FILE: test/stwg_sample_checker.sv
`timescale 1ns / 1ps

module stwg_sample_checker
	import stwg_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic [CFG_INDEX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic                        start_req,
	input  logic signed [MIX_W-1:0]     mix_sample,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic signed [SAMPLE_W-1:0]  sample,
	input  logic [COUNT_W-1:0]          sample_index,
	input  logic                        last,
	output int                          errors,
	output int                          pending
);

	localparam int ADDR_BITS = 10;
	localparam int FRAC_BITS = 15;
	localparam int QUARTER_LEN = (1 << ADDR_BITS) + 1;
	localparam longint unsigned FIX_ONE = 64'd1 << 30;
	localparam longint unsigned FIX_HALF_PI = 64'd1686629713;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] value;
		logic [COUNT_W-1:0]         index;
		logic                       last;
	} wave_sample_t;

	wave_sample_t expected_samples[$];
	logic [FRAC_BITS:0] quarter_sine [QUARTER_LEN];

	logic                wave_sel;
	logic [AMP_W-1:0]    amp_reg;
	logic [STEP_W-1:0]   step_reg;
	logic [OFFSET_W-1:0] offset_reg;
	logic [COUNT_W-1:0]  count_reg;
	logic                mix_on;

	logic [STEP_W-1:0]   phase;
	logic [COUNT_W-1:0]  counter;
	logic                idle;

	// Taylor series of sine up to the thirteenth power, unsigned Q30, every step truncated.
	function automatic longint unsigned series_sine(input longint unsigned x);
		longint unsigned divisor [6] = '{156, 110, 72, 42, 20, 6};
		longint unsigned x2;
		longint unsigned t;
		longint unsigned d;
		x2 = (x * x) >> 30;
		t = FIX_ONE;
		for (int i = 0; i < 6; i++) begin
			d = ((x2 * t) >> 30) / divisor[i];
			t = (d > FIX_ONE) ? 64'd0 : FIX_ONE - d;
		end
		return (x * t) >> 30;
	endfunction

	initial begin
		longint unsigned s;
		longint unsigned v;
		for (int k = 0; k < QUARTER_LEN; k++) begin
			s = series_sine((FIX_HALF_PI * 64'(k)) >> ADDR_BITS);
			v = (s + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
			if (v > (64'd1 << FRAC_BITS))
				v = 64'd1 << FRAC_BITS;
			quarter_sine[k] = v[FRAC_BITS:0];
		end
	end

	function automatic logic signed [FRAC_BITS+1:0] unit_wave(input logic triangle,
		input logic [STEP_W-1:0] ph);
		logic [1:0]                 quad;
		logic [ADDR_BITS-1:0]       addr;
		logic [FRAC_BITS-1:0]       frac;
		logic signed [FRAC_BITS+1:0] mag;
		quad = ph[STEP_W-1 -: 2];
		addr = ph[STEP_W-3 -: ADDR_BITS];
		frac = ph[STEP_W-3 -: FRAC_BITS];
		if (triangle) begin
			mag = quad[0] ? (1 << FRAC_BITS) - frac : frac;
		end else begin
			mag = quad[0] ? quarter_sine[(1 << ADDR_BITS) - addr] : quarter_sine[addr];
		end
		return quad[1] ? -mag : mag;
	endfunction

	task automatic synthesize_sample(input logic restart, input logic signed [MIX_W-1:0] mix);
		longint       prod;
		longint       mag;
		longint       total;
		logic         final_one;
		wave_sample_t s;
		if (restart) begin
			phase = '0;
			counter = '0;
			idle = (count_reg == 0);
		end
		if (idle)
			return;
		prod = longint'(amp_reg) * longint'(unit_wave(wave_sel, phase));
		mag = (prod < 0) ? -prod : prod;
		mag = (mag + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		total = ((prod < 0) ? -mag : mag) + longint'(offset_reg)
			+ (mix_on ? longint'(mix) : 64'sd0);
		final_one = (33'(counter) + 33'd1) >= 33'(count_reg);
		s.value = total[SAMPLE_W-1:0];
		s.index = counter;
		s.last = final_one;
		expected_samples.insert(expected_samples.size(), s);
		counter = counter + 1'b1;
		phase = phase + step_reg;
		if (final_one)
			idle = 1'b1;
	endtask

	task automatic check_sample();
		wave_sample_t want;
		if (expected_samples.size() == 0) begin
			errors++;
			$display("%0t: unexpected sample: expected none, actual value %0d index %0d last %0b",
				$time, sample, sample_index, last);
			return;
		end
		want = expected_samples.pop_front();
		if (sample !== want.value) begin
			errors++;
			$display("%0t: sample value mismatch: expected %0d, actual %0d",
				$time, $signed(want.value), sample);
		end
		if (sample_index !== want.index) begin
			errors++;
			$display("%0t: sample_index mismatch: expected %0d, actual %0d",
				$time, want.index, sample_index);
		end
		if (last !== want.last) begin
			errors++;
			$display("%0t: last mismatch: expected %0b, actual %0b", $time, want.last, last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_sel = 1'b0;
			amp_reg = '0;
			step_reg = '0;
			offset_reg = '0;
			count_reg = '0;
			mix_on = 1'b0;
			phase = '0;
			counter = '0;
			idle = 1'b1;
			expected_samples.delete();
			pending <= 0;
		end else begin
			// A register write takes effect from the request after the one accepted with it.
			if (in_valid && in_ready)
				synthesize_sample(start_req, mix_sample);
			if (out_valid && out_ready)
				check_sample();
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_WAVE_SELECT:  wave_sel = cfg_data[0];
					CFG_AMPLITUDE:    amp_reg = cfg_data[AMP_W-1:0];
					CFG_PHASE_STEP:   step_reg = cfg_data[STEP_W-1:0];
					CFG_OFFSET:       offset_reg = cfg_data[OFFSET_W-1:0];
					CFG_SAMPLE_COUNT: count_reg = cfg_data[COUNT_W-1:0];
					CFG_MIX_ENABLE:   mix_on = cfg_data[0];
					default: ;
				endcase
			end
			pending <= expected_samples.size();
		end
	end

endmodule

FILE: test/tb_sine_triangle_wave_generator.sv
`timescale 1ns / 1ps

module tb_sine_triangle_wave_generator;
	import stwg_pkg::*;

	localparam int LONG_HOLD = 300;
	localparam int STALL_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS = 750;
	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_LO = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_HI = 3'd7;
	localparam logic [MIX_W-1:0] MIX_MAX = {1'b0, {(MIX_W-1){1'b1}}};
	localparam logic [MIX_W-1:0] MIX_MIN = {1'b1, {(MIX_W-1){1'b0}}};

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CFG_INDEX_W-1:0]     cfg_index = '0;
	logic [CFG_DATA_W-1:0]      cfg_data = '0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic                       start_req = 1'b0;
	logic signed [MIX_W-1:0]    mix_sample = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic signed [SAMPLE_W-1:0] sample;
	logic [COUNT_W-1:0]         sample_index;
	logic                       last;
	int                         errors;
	int                         pending;

	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	int   items_sent = 0;
	int   hold_cnt = 0;
	int   idle_cycles = 0;
	logic hold_token = 1'b0;
	logic hold_seen = 1'b0;

	always #10 clk = ~clk;

	sine_triangle_wave_generator dut (.*);

	stwg_sample_checker u_checker (.*);

	always @(posedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen <= hold_token;
			hold_cnt <= LONG_HOLD;
			out_ready <= 1'b0;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cfg_valid && cfg_ready) || (in_valid && in_ready)
			|| (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			if (idle_cycles >= STALL_LIMIT) begin
				$display("FAIL sine_triangle_wave_generator");
				$finish;
			end
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_item(input logic start, input logic [MIX_W-1:0] mix);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		start_req <= start;
		mix_sample <= mix;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	// Stop requests and wait until every expected sample has come out.
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic write_one(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		drain();
		cfg_write(idx, data);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_config(input logic [31:0] wave, input logic [31:0] amp,
		input logic [31:0] step, input logic [31:0] off, input logic [31:0] cnt,
		input logic [31:0] mix_en);
		drain();
		cfg_write(CFG_WAVE_SELECT, wave);
		cfg_write(CFG_AMPLITUDE, amp);
		cfg_write(CFG_PHASE_STEP, step);
		cfg_write(CFG_OFFSET, off);
		cfg_write(CFG_SAMPLE_COUNT, cnt);
		cfg_write(CFG_MIX_ENABLE, mix_en);
		cfg_write($urandom_range(1) ? CFG_UNUSED_LO : CFG_UNUSED_HI, $urandom);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] pick_level();
		logic [31:0] junk;
		junk = $urandom & 32'hFFFF_0000;
		case ($urandom_range(3))
			0: return junk;
			1: return junk | 32'h0000_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_step();
		case ($urandom_range(4))
			0: return '0;
			1: return '1;
			2: return $urandom;
			default: return $urandom >> $urandom_range(31);
		endcase
	endfunction

	function automatic logic [31:0] pick_flag(input logic [1:0] code);
		return ($urandom & ~32'd1) | 32'(code);
	endfunction

	task automatic run_sequence(input int ticks, input bit pressure);
		int cut;
		cut = ($urandom_range(9) == 0) ? ticks / 2 : -1;
		if (pressure)
			hold_token <= ~hold_token;
		for (int i = 0; i < ticks; i++) begin
			if (i == cut && i > 0)
				write_one(CFG_SAMPLE_COUNT, $urandom_range(ticks));
			send_item(i == 0 || $urandom_range(99) < 3, MIX_W'($urandom));
		end
	endtask

	task automatic random_sequence(input bit pressure);
		logic [31:0] cnt;
		int          ticks;
		int          pick;
		pick = $urandom_range(99);
		if (pressure) begin
			cnt = 80;
			ticks = 80;
		end else if (pick < 8) begin
			cnt = '0;
			ticks = $urandom_range(1, 3);
		end else if (pick < 20) begin
			cnt = $urandom_range(1) ? 32'hFFFF_FFFF : ($urandom | 32'h100);
			ticks = $urandom_range(1, 40);
		end else begin
			cnt = $urandom_range(1, 40);
			ticks = cnt + $urandom_range(0, 2);
		end
		load_config(pick_flag($urandom_range(1) ? WAVE_TRIANGLE : WAVE_SINE), pick_level(),
			pick_step(), pick_level(), cnt, pick_flag(2'($urandom_range(1))));
		run_sequence(ticks, pressure);
	endtask

	initial begin
		int base;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Requests while idle after reset produce nothing.
		send_item(1'b0, MIX_MAX);
		send_item(1'b0, MIX_MIN);

		// Quarter-turn steps hit the sine peaks and zero crossings, mixed at the extremes.
		load_config(32'(WAVE_SINE), 32'h0000_FFFF, 32'h4000_0000, 32'd0, 32'd6, 32'd1);
		send_item(1'b1, MIX_MIN);
		send_item(1'b0, MIX_MAX);
		send_item(1'b0, '0);
		send_item(1'b0, '1);
		send_item(1'b0, MIX_MIN);
		send_item(1'b0, MIX_MAX);
		send_item(1'b0, '0);

		// A start with a zero sample count stays idle.
		load_config(32'(WAVE_TRIANGLE), 32'h0000_FFFF, 32'h1000_0000, 32'h0000_FFFF,
			32'd0, 32'd0);
		send_item(1'b1, MIX_MAX);
		send_item(1'b0, MIX_MIN);

		// Lowering the count in the middle of a run ends it on the next sample.
		write_one(CFG_SAMPLE_COUNT, 32'd10);
		send_item(1'b1, MIX_MAX);
		send_item(1'b0, MIX_MIN);
		send_item(1'b0, '0);
		send_item(1'b0, '1);
		write_one(CFG_SAMPLE_COUNT, 32'd2);
		send_item(1'b0, MIX_MAX);
		send_item(1'b0, MIX_MIN);

		// Zero amplitude, full step and count, and a restart in the middle of a run.
		load_config(32'(WAVE_SINE), 32'd0, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'hFFFF_FFFF, 32'd1);
		send_item(1'b1, MIX_MIN);
		send_item(1'b0, MIX_MAX);
		send_item(1'b1, '1);
		send_item(1'b0, '0);

		base = items_sent;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct <= 0;
				end
				1: begin
					send_idle_pct = 67;
					recv_stall_pct <= 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct <= 67;
				end
				default: begin
					send_idle_pct = 12;
					recv_stall_pct <= 12;
				end
			endcase
			random_sequence(ph == 0);
			while (items_sent < base + (ph + 1) * RANDOM_ITEMS / 4)
				random_sequence(1'b0);
		end

		drain();
		if (errors == 0)
			$display("PASS sine_triangle_wave_generator");
		else
			$display("FAIL sine_triangle_wave_generator");
		$finish;
	end

endmodule

FILE: sine_triangle_wave_generator.f
rtl/stwg_pkg.sv
rtl/sine_triangle_wave_generator.sv
test/stwg_sample_checker.sv
test/tb_sine_triangle_wave_generator.sv
